/* src/cma_pkg.sv */
// shared types and constants of the centered moving average filter
`timescale 1ns / 1ps

package cma_pkg;

    // fixed field widths
    localparam int SAMPLE_W   = 16;
    localparam int AVG_W      = 24;
    localparam int WREQ_W     = 7;
    localparam int RLEN_W     = 21;
    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = 21;
    localparam int FRAC_BITS  = 8;

    // register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_WINDOW_REQUEST = 1'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_RECORD_LENGTH  = 1'd1;

    // register reset values
    localparam logic [WREQ_W-1:0] DEFAULT_WINDOW = 7'd3;
    localparam logic [RLEN_W-1:0] DEFAULT_RECORD = 21'd1;

    // commands from the controller to the datapath
    typedef struct packed {
        logic accept;      // input beat taken, latch sample
        logic start_rec;   // first sample of a record, latch record settings
        logic rd_issue;    // read delay line at the pointer
        logic upd_sample;  // add new sample, retire oldest, store sample
        logic upd_flush;   // retire oldest without a new sample
        logic div_start;   // launch the divider on the running sum
        logic load_out;    // move the quotient into the output register
        logic last;        // last flag for the loaded result
    } cma_cmd_t;

    // status from the datapath to the controller
    typedef struct packed {
        logic index_zero;  // next sample opens a record
        logic result_due;  // current sample produces a result
        logic rec_end;     // current sample closes the record
        logic half_zero;   // no trailing outputs in this record
        logic flush_done;  // all trailing outputs produced
        logic flush_final; // the next trailing output is the last one
        logic div_done;    // quotient ready
        logic out_free;    // output register can take a value
    } cma_sts_t;

endpackage

/* src/cma_divider.sv */
// restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps

module cma_divider #(
    parameter int NUM_W = 33,
    parameter int DEN_W = 8
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [NUM_W-1:0] dividend,
    input  logic [DEN_W-1:0] divisor,
    output logic [NUM_W-1:0] quotient,
    output logic             done
);
    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] quo_reg, quo_next;
    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [DEN_W-1:0] den_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [DEN_W:0]   trial;
    logic             fits;

    // one shift-subtract step
    always_comb begin
        trial    = {rem_reg, quo_reg[NUM_W-1]};
        fits     = trial >= {1'b0, den_reg};
        rem_next = fits ? DEN_W'(trial - {1'b0, den_reg}) : trial[DEN_W-1:0];
        quo_next = {quo_reg[NUM_W-2:0], fits};
    end

    // control of the iteration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(NUM_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // operand and partial result registers
    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= dividend;
            rem_reg <= '0;
            den_reg <= divisor;
        end else if (busy_reg) begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign quotient = quo_reg;
    assign done     = done_reg;

endmodule

/* src/cma_datapath.sv */
// delay line, running sum, record counters, divider and output register
`timescale 1ns / 1ps

module cma_datapath #(
    parameter int MAX_WINDOW = 64,
    parameter int MAX_RECORD = 1048576
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [cma_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [cma_pkg::CFG_DATA_W-1:0] cfg_wr_data,
    input  logic [cma_pkg::SAMPLE_W-1:0]  sample,
    input  logic                          m_tready,
    output logic [cma_pkg::AVG_W-1:0]     average,
    output logic                          last_of_record,
    output logic                          m_tvalid,
    input  cma_pkg::cma_cmd_t             cmd,
    output cma_pkg::cma_sts_t             sts
);
    import cma_pkg::*;

    localparam int PTR_W = $clog2(MAX_WINDOW);
    localparam int WIN_W = $clog2(MAX_WINDOW + 1);
    localparam int LEN_W = $clog2(MAX_RECORD + 1);
    localparam int SUM_W = SAMPLE_W + PTR_W + 1;
    localparam int NUM_W = SUM_W + FRAC_BITS + 2;
    localparam int DEN_W = WIN_W + 1;

    // configuration registers
    logic [WREQ_W-1:0] win_req_reg;
    logic [RLEN_W-1:0] rec_cfg_reg;

    // record state
    logic [WIN_W-1:0]  win_reg;
    logic [WIN_W-1:0]  half_reg;
    logic [LEN_W-1:0]  rec_len_reg;
    logic [LEN_W-1:0]  index_reg;
    logic [PTR_W-1:0]  ptr_reg;
    logic              filled_reg;
    logic [WIN_W-1:0]  fcnt_reg;
    logic signed [SUM_W-1:0]    sum_reg;
    logic signed [SAMPLE_W-1:0] x_reg;

    // delay line memory
    logic signed [SAMPLE_W-1:0] line_mem [MAX_WINDOW];
    logic signed [SAMPLE_W-1:0] rd_reg;

    // division operands and output
    logic              neg_reg;
    logic [AVG_W-1:0]  avg_reg;
    logic              last_reg;
    logic              valid_reg;

    logic [31:0]       len32, win32;
    logic [LEN_W-1:0]  len_c;
    logic [WIN_W-1:0]  win_c;
    logic [WIN_W-1:0]  ptr_inc;
    logic              ptr_wrap;
    logic signed [SUM_W-1:0] old_val;
    logic [SUM_W-1:0]  mag;
    logic [NUM_W-1:0]  num;
    logic [DEN_W-1:0]  den;
    logic [NUM_W-1:0]  quo;
    logic [AVG_W-1:0]  quo_low;
    logic              div_done;

    // settings of a new record from the registers
    always_comb begin
        len32 = 32'(rec_cfg_reg);
        if (len32 == 32'd0) begin
            len32 = 32'd1;
        end
        if (len32 > 32'(MAX_RECORD)) begin
            len32 = 32'(MAX_RECORD);
        end
        win32 = 32'(win_req_reg);
        if (win32 < 32'd1 || win32 > len32 || win32 > 32'(MAX_WINDOW)) begin
            win32 = 32'd1;
        end
        len_c = LEN_W'(len32);
        win_c = WIN_W'(win32);
    end

    // pointer wrap and oldest sample
    assign ptr_inc  = WIN_W'(ptr_reg) + WIN_W'(1);
    assign ptr_wrap = ptr_inc == win_reg;
    assign old_val  = filled_reg ? SUM_W'(rd_reg) : '0;

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_req_reg <= DEFAULT_WINDOW;
            rec_cfg_reg <= DEFAULT_RECORD;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                REG_WINDOW_REQUEST: win_req_reg <= cfg_wr_data[WREQ_W-1:0];
                REG_RECORD_LENGTH:  rec_cfg_reg <= cfg_wr_data[RLEN_W-1:0];
                default: ;
            endcase
        end
    end

    // record state, pointer and running sum
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_reg     <= WIN_W'(1);
            half_reg    <= '0;
            rec_len_reg <= LEN_W'(1);
            index_reg   <= '0;
            ptr_reg     <= '0;
            filled_reg  <= 1'b0;
            fcnt_reg    <= '0;
            sum_reg     <= '0;
        end else begin
            if (cmd.start_rec) begin
                win_reg     <= win_c;
                half_reg    <= win_c >> 1;
                rec_len_reg <= len_c;
                ptr_reg     <= '0;
                filled_reg  <= 1'b0;
                sum_reg     <= '0;
            end
            if (cmd.upd_sample) begin
                sum_reg  <= sum_reg + SUM_W'(x_reg) - old_val;
                ptr_reg  <= ptr_wrap ? '0 : ptr_inc[PTR_W-1:0];
                fcnt_reg <= '0;
                if (ptr_wrap) begin
                    filled_reg <= 1'b1;
                end
                index_reg <= sts.rec_end ? '0 : index_reg + LEN_W'(1);
            end
            if (cmd.upd_flush) begin
                sum_reg  <= sum_reg - SUM_W'(rd_reg);
                ptr_reg  <= ptr_wrap ? '0 : ptr_inc[PTR_W-1:0];
                fcnt_reg <= fcnt_reg + WIN_W'(1);
            end
        end
    end

    // input sample latch
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            x_reg <= $signed(sample);
        end
    end

    // delay line write and registered read
    always_ff @(posedge aclk) begin
        if (cmd.upd_sample) begin
            line_mem[ptr_reg] <= x_reg;
        end
        if (cmd.rd_issue) begin
            rd_reg <= line_mem[ptr_reg];
        end
    end

    // rounded division operands: (2*|sum|*256 + W) / (2*W)
    assign mag = sum_reg[SUM_W-1] ? SUM_W'(-sum_reg) : SUM_W'(sum_reg);
    assign num = (NUM_W'(mag) << (FRAC_BITS + 1)) + NUM_W'(win_reg);
    assign den = {win_reg, 1'b0};

    always_ff @(posedge aclk) begin
        if (cmd.div_start) begin
            neg_reg <= sum_reg[SUM_W-1];
        end
    end

    cma_divider #(
        .NUM_W (NUM_W),
        .DEN_W (DEN_W)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (num),
        .divisor  (den),
        .quotient (quo),
        .done     (div_done)
    );

    assign quo_low = quo[AVG_W-1:0];

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (cmd.load_out) begin
            valid_reg <= 1'b1;
        end else if (m_tready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            avg_reg  <= neg_reg ? AVG_W'(-quo_low) : quo_low;
            last_reg <= cmd.last;
        end
    end

    assign average        = avg_reg;
    assign last_of_record = last_reg;
    assign m_tvalid       = valid_reg;

    // status toward the controller
    always_comb begin
        sts.index_zero  = index_reg == '0;
        sts.result_due  = 32'(index_reg) >= 32'(half_reg);
        sts.rec_end     = index_reg == rec_len_reg - LEN_W'(1);
        sts.half_zero   = half_reg == '0;
        sts.flush_done  = fcnt_reg == half_reg;
        sts.flush_final = fcnt_reg + WIN_W'(1) == half_reg;
        sts.div_done    = div_done;
        sts.out_free    = !valid_reg || m_tready;
    end

endmodule

/* src/cma_ctrl.sv */
// controller that sequences sample update, trailing flush and division
`timescale 1ns / 1ps

module cma_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  cma_pkg::cma_sts_t sts,
    output cma_pkg::cma_cmd_t cmd
);
    import cma_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_UPD,
        S_DSTART,
        S_DWAIT,
        S_LOAD,
        S_FREAD,
        S_FUPD
    } state_t;

    state_t state_reg;
    logic   flush_pend_reg;
    logic   last_reg;

    // state and flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            flush_pend_reg <= 1'b0;
            last_reg       <= 1'b0;
        end else begin
            case (state_reg)
                S_IDLE: begin
                    if (s_tvalid) begin
                        state_reg <= S_READ;
                    end
                end
                S_READ: state_reg <= S_UPD;
                S_UPD: begin
                    flush_pend_reg <= sts.rec_end && !sts.half_zero;
                    last_reg       <= sts.rec_end && sts.half_zero;
                    if (sts.result_due) begin
                        state_reg <= S_DSTART;
                    end else if (sts.rec_end && !sts.half_zero) begin
                        state_reg <= S_FREAD;
                    end else begin
                        state_reg <= S_IDLE;
                    end
                end
                S_DSTART: state_reg <= S_DWAIT;
                S_DWAIT: begin
                    if (sts.div_done) begin
                        state_reg <= S_LOAD;
                    end
                end
                S_LOAD: begin
                    if (sts.out_free) begin
                        if (flush_pend_reg && !sts.flush_done) begin
                            state_reg <= S_FREAD;
                        end else begin
                            flush_pend_reg <= 1'b0;
                            state_reg      <= S_IDLE;
                        end
                    end
                end
                S_FREAD: state_reg <= S_FUPD;
                S_FUPD: begin
                    last_reg  <= sts.flush_final;
                    state_reg <= S_DSTART;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // command decode
    always_comb begin
        s_tready       = state_reg == S_IDLE;
        cmd.accept     = s_tready && s_tvalid;
        cmd.start_rec  = cmd.accept && sts.index_zero;
        cmd.rd_issue   = state_reg == S_READ || state_reg == S_FREAD;
        cmd.upd_sample = state_reg == S_UPD;
        cmd.upd_flush  = state_reg == S_FUPD;
        cmd.div_start  = state_reg == S_DSTART;
        cmd.load_out   = state_reg == S_LOAD && sts.out_free;
        cmd.last       = last_reg;
    end

endmodule

/* src/centered_moving_average.sv */
// top level of the centered moving average filter
//
//  channel  | direction | handshake          | content
//  ---------+-----------+--------------------+-------------------------------------
//  s_       | in        | s_tvalid/s_tready  | tdata[15:0] sample
//  m_       | out       | m_tvalid/m_tready  | tdata[23:0] average, tlast last_of_record
//  cfg_     | in        | cfg_wr_en          | cfg_addr register index, cfg_wr_data
//
// a sample goes through accept, delay line read and sum update; each result then
// adds a divide by the bit-serial divider over the NUM_W = 27 + clog2(MAX_WINDOW)
// bit dividend (NUM_W = 33 for MAX_WINDOW = 64) and a load into the output register
// the last sample adds half the window of trailing results, each with its own
// delay line read and sum update
// reset is synchronous, active low, and returns to the first sample of a record
// a result waits in the output register under m_tready low; the next beat is
// taken only after the previous sample's results are in that register
`timescale 1ns / 1ps

module centered_moving_average #(
    parameter int MAX_WINDOW = 64,
    parameter int MAX_RECORD = 1048576
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // configuration writes
    input  logic                           cfg_wr_en,
    input  logic [cma_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [cma_pkg::CFG_DATA_W-1:0] cfg_wr_data,
    // input samples
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [15:0]                    s_tdata,   // [15:0] sample
    // averaged results
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [23:0]                    m_tdata,   // [23:0] average
    output logic                           m_tlast
);
    import cma_pkg::*;

    cma_cmd_t cmd;
    cma_sts_t sts;

    cma_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    cma_datapath #(
        .MAX_WINDOW (MAX_WINDOW),
        .MAX_RECORD (MAX_RECORD)
    ) u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_addr       (cfg_addr),
        .cfg_wr_data    (cfg_wr_data),
        .sample         (s_tdata),
        .m_tready       (m_tready),
        .average        (m_tdata),
        .last_of_record (m_tlast),
        .m_tvalid       (m_tvalid),
        .cmd            (cmd),
        .sts            (sts)
    );

endmodule

/* dv/tb.sv */
// self-checking testbench for the centered moving average filter
`timescale 1ns / 1ps

module tb;

    import cma_pkg::*;

    localparam int MAX_WINDOW    = 64;
    localparam int MAX_RECORD    = 1048576;
    localparam int SETTLE_CYCLES = 48;    // a sample plus one divide, with margin
    localparam int STALL_LIMIT   = 2000;  // cycles without any beat before giving up

    typedef struct packed {
        logic [AVG_W-1:0] average;
        logic             last;
    } avg_beat_t;

    logic                  aclk        = 1'b0;
    logic                  aresetn     = 1'b0;
    logic                  cfg_wr_en   = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr    = REG_WINDOW_REQUEST;
    logic [CFG_DATA_W-1:0] cfg_wr_data = '0;
    logic                  s_tvalid    = 1'b0;
    logic                  s_tready;
    logic [15:0]           s_tdata     = '0;  // [15:0] sample
    logic                  m_tvalid;
    logic                  m_tready    = 1'b0;
    logic [23:0]           m_tdata;           // [23:0] average
    logic                  m_tlast;

    // idle rates in percent of cycles
    int unsigned send_idle_pct = 22;
    int unsigned recv_idle_pct = 61;
    int unsigned error_count   = 0;
    int unsigned idle_cycles   = 0;

    // filter state mirrored in the testbench
    logic [WREQ_W-1:0]        window_reg = DEFAULT_WINDOW;
    logic [RLEN_W-1:0]        length_reg = DEFAULT_RECORD;
    logic signed [SAMPLE_W-1:0] delay_line [MAX_WINDOW];
    longint                   window_sum = 0;
    int unsigned              rec_pos    = 0;
    int unsigned              eff_window = 1;
    int unsigned              eff_half   = 0;
    int unsigned              eff_length = 1;
    int unsigned              line_ptr   = 0;

    avg_beat_t expected_avgs [$];
    avg_beat_t want;

    centered_moving_average #(
        .MAX_WINDOW (MAX_WINDOW),
        .MAX_RECORD (MAX_RECORD)
    ) dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast)
    );

    // 8 ns clock
    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // rounded mean of the current window sum, ties away from zero
    function automatic void push_average(input logic last);
        longint    num = window_sum * 256;
        longint    mag;
        longint    quo;
        longint    val;
        avg_beat_t beat;
        mag = (num < 0) ? -num : num;
        quo = (2 * mag + longint'(eff_window)) / (2 * longint'(eff_window));
        val = (num < 0) ? -quo : quo;
        beat.average = val[AVG_W-1:0];
        beat.last    = last;
        expected_avgs.push_back(beat);
    endfunction

    function automatic void advance_line();
        line_ptr++;
        if (line_ptr >= eff_window) begin
            line_ptr = 0;
        end
    endfunction

    // expected averages caused by one accepted sample
    function automatic void filter_sample(input logic [SAMPLE_W-1:0] raw);
        int unsigned n;
        // first sample of a record latches the settings
        if (rec_pos == 0) begin
            eff_length = (length_reg == 0) ? 1 : 32'(length_reg);
            if (eff_length > MAX_RECORD) begin
                eff_length = MAX_RECORD;
            end
            eff_window = 32'(window_reg);
            if (eff_window < 1 || eff_window > eff_length || eff_window > MAX_WINDOW) begin
                eff_window = 1;
            end
            eff_half   = eff_window / 2;
            line_ptr   = 0;
            window_sum = 0;
            foreach (delay_line[i]) begin
                delay_line[i] = '0;
            end
        end
        window_sum += longint'($signed(raw)) - longint'(delay_line[line_ptr]);
        delay_line[line_ptr] = raw;
        advance_line();
        n = rec_pos;
        if (n >= eff_half) begin
            push_average(n == eff_length - 1 && eff_half == 0);
        end
        // last sample flushes the trailing outputs
        if (n >= eff_length - 1) begin
            for (int unsigned i = 0; i < eff_half; i++) begin
                window_sum -= longint'(delay_line[line_ptr]);
                delay_line[line_ptr] = '0;
                advance_line();
                push_average(i == eff_half - 1);
            end
            rec_pos = 0;
        end else begin
            rec_pos = n + 1;
        end
    endfunction

    // result checker, receiver stalls and stall watchdog count
    always @(posedge aclk) begin
        if (m_tvalid && m_tready) begin
            if (expected_avgs.size() == 0) begin
                $display("%0t: unexpected beat: expected none, actual average %0d last %0b",
                         $time, $signed(m_tdata), m_tlast);
                error_count++;
            end else begin
                want = expected_avgs.pop_front();
                if (m_tdata !== want.average) begin
                    $display("%0t: average mismatch: expected %0d, actual %0d",
                             $time, $signed(want.average), $signed(m_tdata));
                    error_count++;
                end
                if (m_tlast !== want.last) begin
                    $display("%0t: last mismatch: expected %0b, actual %0b",
                             $time, want.last, m_tlast);
                    error_count++;
                end
            end
        end
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // watchdog
    initial begin
        wait (idle_cycles >= STALL_LIMIT);
        $display("%0t: no beat for %0d cycles", $time, STALL_LIMIT);
        $display("DONE: errors detected");
        $finish;
    end

    // one sample beat with a random gap in front
    task automatic send_sample(input logic [SAMPLE_W-1:0] value);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        do @(posedge aclk); while (!s_tready);
        filter_sample(value);
    endtask

    // stop sending until every expected average is back and the block is idle
    task automatic drain();
        s_tvalid <= 1'b0;
        while (expected_avgs.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // write both registers on consecutive cycles
    task automatic configure(input logic [CFG_DATA_W-1:0] win_val,
                             input logic [CFG_DATA_W-1:0] len_val);
        cfg_wr_en   <= 1'b1;
        cfg_addr    <= REG_WINDOW_REQUEST;
        cfg_wr_data <= win_val;
        @(posedge aclk);
        window_reg  = win_val[WREQ_W-1:0];
        cfg_addr    <= REG_RECORD_LENGTH;
        cfg_wr_data <= len_val;
        @(posedge aclk);
        length_reg  = len_val[RLEN_W-1:0];
        cfg_wr_en   <= 1'b0;
    endtask

    function automatic logic [SAMPLE_W-1:0] random_sample();
        case ($urandom_range(7))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            2:       return 16'($urandom_range(0, 4)) - 16'd2;
            default: return 16'($urandom_range(0, 16'hFFFF));
        endcase
    endfunction

    // random settings, short records mostly, a few long ones
    task automatic pick_settings();
        int unsigned len_val;
        int unsigned win_val;
        case ($urandom_range(9))
            0:       len_val = $urandom_range(60, 80);
            1:       len_val = 0;
            default: len_val = $urandom_range(1, 12);
        endcase
        case ($urandom_range(7))
            0:       win_val = 0;
            1:       win_val = 64;
            2:       win_val = $urandom_range(65, 127);
            3:       win_val = $urandom_range(0, 21'h1FFFFF);
            default: win_val = $urandom_range(1, (len_val == 0) ? 1 : len_val);
        endcase
        if (len_val >= 64 && $urandom_range(1)) begin
            win_val = 64;
        end
        configure(CFG_DATA_W'(win_val), CFG_DATA_W'(len_val));
    endtask

    task automatic test_directed_cases();
        // reset settings: window over a one-sample record collapses to one
        send_sample(16'h7FFF);
        send_sample(16'h8000);
        drain();
        // zero window and zero record length both become one
        configure(21'd0, 21'd0);
        send_sample(16'h0001);
        send_sample(16'hFFFF);
        drain();
        // even window over a full record of extremes, with flush
        configure(21'd4, 21'd5);
        send_sample(16'h7FFF);
        send_sample(16'h7FFF);
        send_sample(16'h8000);
        send_sample(16'h8000);
        send_sample(16'h0001);
        drain();
        // window above record length becomes one
        configure(21'd10, 21'd4);
        send_sample(16'h0003);
        send_sample(16'hFFFD);
        send_sample(16'h0100);
        send_sample(16'hFF00);
        drain();
        // register write mid record applies from the next record only
        configure(21'd3, 21'd3);
        send_sample(16'h0001);
        send_sample(16'hFFFE);
        drain();
        configure(21'h1FFFFF, 21'd2);
        send_sample(16'h5555);
        send_sample(16'hAAAA);
        send_sample(16'h1234);
        drain();
    endtask

    task automatic test_random_records(input int unsigned budget);
        int unsigned sent;
        int unsigned in_rec;
        int unsigned split_at;
        bit          first;
        sent  = 0;
        first = 1'b1;
        while (sent < budget) begin
            // new settings for some records, back to back otherwise
            if (first || $urandom_range(1)) begin
                drain();
                pick_settings();
                first = 1'b0;
            end
            split_at = ($urandom_range(5) == 0) ? $urandom_range(1, 8) : 0;
            in_rec   = 0;
            do begin
                send_sample(random_sample());
                sent++;
                in_rec++;
                // settings rewritten with a record in progress
                if (in_rec == split_at && rec_pos != 0) begin
                    drain();
                    pick_settings();
                end
            end while (rec_pos != 0);
        end
    endtask

    // oversized record length saturates; the record stays open at the end
    task automatic test_saturated_record();
        drain();
        configure(21'd64, 21'h1FFFFF);
        repeat (40) send_sample(random_sample());
    endtask

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed_cases();
        test_random_records(85);
        send_idle_pct = 61;
        recv_idle_pct = 22;
        test_random_records(85);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_records(80);
        test_saturated_record();
        drain();
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
